>>> design/uad_pkg.sv
`default_nettype none

package uad_pkg;

  // Default sizes of the streamed grid and the fixed-point format.
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned FracBitsDef  = 24;

  // Field widths fixed by the interface.
  localparam int unsigned SampleW  = 32;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned DiffW    = SampleW + 1;
  localparam int unsigned ProdW    = CoefW + DiffW;
  localparam int unsigned SizeW    = 11;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned DcoefW   = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Smallest grid edge that still has an interior cell.
  localparam int unsigned MinSize = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgGridWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGridHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAdvXCoef   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAdvYCoef   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDiffXCoef  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDiffYCoef  = 3'd5;

  typedef logic signed [SampleW-1:0] sample_t;

  localparam sample_t SatMax = 32'sh7fff_ffff;
  localparam sample_t SatMin = 32'sh8000_0000;

  typedef struct packed {
    sample_t sample;
    logic    frame_start;
  } in_item_t;

  typedef struct packed {
    sample_t             new_value;
    logic [IdxW-1:0]     cell_row;
    logic [IdxW-1:0]     cell_col;
    logic                frame_last;
  } out_item_t;

  // One column of the 3x3 window, top row first.
  typedef struct packed {
    sample_t top;
    sample_t mid;
    sample_t bot;
  } win_col_t;

  // Position information that travels beside a cell through the pipeline.
  typedef struct packed {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            last;
  } cell_meta_t;

endpackage

`default_nettype wire

>>> design/uad_line_buf.sv
`default_nettype none

module uad_line_buf import uad_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef,
  localparam int unsigned AddrW = $clog2(MAX_WIDTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire sample_t          wr_data_i,
  output sample_t               top_o,
  output sample_t               mid_o
);

  // Buffer A holds the previous row, buffer B the row before it. A is
  // written with the new sample in the same cycle as it is read; B gets the
  // old A entry in the following cycle, once that entry has come out of A.
  sample_t mem_a [MAX_WIDTH];
  sample_t mem_b [MAX_WIDTH];
  sample_t a_rd_q;
  sample_t b_rd_q;

  logic             pend_q;
  logic [AddrW-1:0] pend_addr_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      a_rd_q         <= mem_a[addr_i];
      mem_a[addr_i]  <= wr_data_i;
    end
  end

  // A read that hits the entry still waiting to be written takes the
  // waiting data instead.
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      mem_b[pend_addr_q] <= a_rd_q;
    end
    if (rd_en_i) begin
      if (pend_q && (pend_addr_q == addr_i)) begin
        b_rd_q <= a_rd_q;
      end else begin
        b_rd_q <= mem_b[addr_i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= rd_en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      pend_addr_q <= addr_i;
    end
  end

  assign top_o = b_rd_q;
  assign mid_o = a_rd_q;

endmodule

`default_nettype wire

>>> design/uad_win_col.sv
`default_nettype none

module uad_win_col import uad_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire win_col_t col_i,
  output win_col_t      col_o
);

  // One window column; on every new sample it takes over its newer
  // neighbor's column.
  win_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

>>> design/uad_term.sv
`default_nettype none

module uad_term import uad_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [CoefW-1:0]           coef_i,
  input  wire logic signed [DiffW-1:0]           diff_i,
  output logic signed [ProdW-FRAC_BITS-1:0]      term_o
);

  localparam int unsigned TermW = ProdW - FRAC_BITS;
  localparam logic signed [ProdW-1:0] RndHalf =
    {{TermW{1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] rnd_sum;
  logic signed [TermW-1:0] term_d;
  logic signed [TermW-1:0] term_q;

  // Exact product in the first stage, round to nearest with ties upward
  // in the second.
  assign prod_d  = coef_i * diff_i;
  assign rnd_sum = prod_q + RndHalf;
  assign term_d  = rnd_sum[ProdW-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

`default_nettype wire

>>> design/upwind_advection_diffusion_stencil.sv
// Upwind advection-diffusion stencil, one explicit Euler step on a 2D grid.
//
// Input channel: one signed Q8.24 sample per transfer in raster order, with
// frame_start marking row 0, column 0. A transfer happens on a rising edge
// with in_valid_i high and in_stall_o low. One sample is taken every such cycle.
// Output channel: one updated interior cell per transfer, with its row,
// column and a flag on the last interior cell of the grid. A result leaves
// when out_valid_o is high and out_stall_i is low.
// The result for cell (r-1, c-1) passes from the transfer of sample (r, c)
// through stage 0, the window, the difference, product, rounding, pair and
// quad registers into the output register behind out_valid_o. Samples in the
// first two rows or the first two columns of the grid produce no result.
// Configuration: six registers written through cfg_valid_i/cfg_ready_o,
// always ready; write them only while no results are outstanding.
// Reset clears the position counters, the window and the pipeline valid bits
// and loads the register defaults; the line buffers are not cleared.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o rises in the same cycle.

`default_nettype none

module upwind_advection_diffusion_stencil import uad_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned RowW  = $clog2(MAX_HEIGHT);
  localparam int unsigned ColXW = ColW + 1;
  localparam int unsigned RowXW = RowW + 1;
  localparam int unsigned WEffW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HEffW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WCmpW = (WEffW > SizeW) ? WEffW : SizeW;
  localparam int unsigned HCmpW = (HEffW > SizeW) ? HEffW : SizeW;
  localparam int unsigned TermW = ProdW - FRAC_BITS;
  localparam int unsigned SumW  = TermW + 3;

  localparam int unsigned WinCols  = 3;
  localparam int unsigned NumTerms = 6;
  localparam int unsigned OutStage = 7;

  // Term lanes.
  localparam int unsigned TermAdvX   = 0;
  localparam int unsigned TermAdvY   = 1;
  localparam int unsigned TermDiffW  = 2;
  localparam int unsigned TermDiffE  = 3;
  localparam int unsigned TermDiffN  = 4;
  localparam int unsigned TermDiffS  = 5;

  // ---------------------------------------------------------------------
  // Configuration registers. The port never pushes back.
  // ---------------------------------------------------------------------
  logic [SizeW-1:0]        gw_q;
  logic [SizeW-1:0]        gh_q;
  logic signed [CoefW-1:0] axc_q;
  logic signed [CoefW-1:0] ayc_q;
  logic [DcoefW-1:0]       dxc_q;
  logic [DcoefW-1:0]       dyc_q;
  logic                    cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q  <= SizeW'(MaxWidthDef);
      gh_q  <= SizeW'(MaxHeightDef);
      axc_q <= '0;
      ayc_q <= '0;
      dxc_q <= '0;
      dyc_q <= '0;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CfgGridWidth:  gw_q  <= cfg_data_i[SizeW-1:0];
        CfgGridHeight: gh_q  <= cfg_data_i[SizeW-1:0];
        CfgAdvXCoef:   axc_q <= $signed(cfg_data_i);
        CfgAdvYCoef:   ayc_q <= $signed(cfg_data_i);
        CfgDiffXCoef:  dxc_q <= cfg_data_i[DcoefW-1:0];
        CfgDiffYCoef:  dyc_q <= cfg_data_i[DcoefW-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid size: a programmed size below the minimum acts as the
  // minimum, one beyond the buffer depth acts as the depth.
  logic [WCmpW-1:0] gw_ext;
  logic [HCmpW-1:0] gh_ext;
  logic [WEffW-1:0] w_eff;
  logic [HEffW-1:0] h_eff;

  assign gw_ext = WCmpW'(gw_q);
  assign gh_ext = HCmpW'(gh_q);

  always_comb begin
    if (gw_ext < WCmpW'(MinSize)) begin
      w_eff = WEffW'(MinSize);
    end else if (gw_ext > WCmpW'(MAX_WIDTH)) begin
      w_eff = WEffW'(MAX_WIDTH);
    end else begin
      w_eff = WEffW'(gw_ext);
    end
    if (gh_ext < HCmpW'(MinSize)) begin
      h_eff = HEffW'(MinSize);
    end else if (gh_ext > HCmpW'(MAX_HEIGHT)) begin
      h_eff = HEffW'(MAX_HEIGHT);
    end else begin
      h_eff = HEffW'(gh_ext);
    end
  end

  // ---------------------------------------------------------------------
  // Flow control. Every stage moves together; the pipeline only holds when
  // the output register is full and the receiver stalls.
  // ---------------------------------------------------------------------
  logic [OutStage:0] v_q;
  logic              adv;
  logic              accept;

  assign adv        = !(v_q[OutStage] && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // ---------------------------------------------------------------------
  // Raster position. A frame start forces row 0, column 0; a stale position
  // left beyond a smaller grid wraps before it is used.
  // ---------------------------------------------------------------------
  logic [ColW-1:0]  col_q;
  logic [ColW-1:0]  col_d;
  logic [ColW-1:0]  c0;
  logic [ColW-1:0]  cur_col;
  logic [RowW-1:0]  row_q;
  logic [RowW-1:0]  row_d;
  logic [RowW-1:0]  r0;
  logic [RowW-1:0]  cur_row;
  logic [RowXW-1:0] r1;
  logic [ColXW-1:0] col_inc;
  logic [RowXW-1:0] row_inc;
  logic             emit_d;
  cell_meta_t       meta_d;

  always_comb begin
    if (in_item_i.frame_start) begin
      c0 = '0;
      r0 = '0;
    end else begin
      c0 = col_q;
      r0 = row_q;
    end

    cur_col = c0;
    r1      = RowXW'(r0);
    if (ColXW'(c0) >= ColXW'(w_eff)) begin
      cur_col = '0;
      r1      = RowXW'(r0) + RowXW'(1);
    end
    if (r1 >= RowXW'(h_eff)) begin
      cur_row = '0;
    end else begin
      cur_row = RowW'(r1);
    end

    col_inc = ColXW'(cur_col) + ColXW'(1);
    row_inc = RowXW'(cur_row) + RowXW'(1);
    if (col_inc >= ColXW'(w_eff)) begin
      col_d = '0;
      if (row_inc >= RowXW'(h_eff)) begin
        row_d = '0;
      end else begin
        row_d = RowW'(row_inc);
      end
    end else begin
      col_d = ColW'(col_inc);
      row_d = cur_row;
    end

    // The cell one up and one left of this sample is interior once both
    // coordinates reach two.
    emit_d      = (cur_row >= RowW'(2)) && (cur_col >= ColW'(2));
    meta_d.row  = IdxW'(cur_row - RowW'(1));
    meta_d.col  = IdxW'(cur_col - ColW'(1));
    meta_d.last = (row_inc == RowXW'(h_eff)) && (col_inc == ColXW'(w_eff));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: line buffers are read at the current column, and the sample
  // and its position are registered.
  // ---------------------------------------------------------------------
  sample_t    lb_top;
  sample_t    lb_mid;
  sample_t    s0_sample_q;
  logic       emit0_q;
  cell_meta_t meta_q [OutStage];

  uad_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .addr_i    (cur_col),
    .wr_data_i (in_item_i.sample),
    .top_o     (lb_top),
    .mid_o     (lb_mid)
  );

  // ---------------------------------------------------------------------
  // Stage 1: the window is a chain of three column cells. The newest column
  // comes from the line buffers and the registered sample; each sample
  // moves every column one place toward the oldest.
  // ---------------------------------------------------------------------
  win_col_t win_chain [WinCols+1];
  logic     win_en;

  assign win_en             = adv && v_q[0];
  assign win_chain[WinCols] = '{top: lb_top, mid: lb_mid, bot: s0_sample_q};

  for (genvar k = 0; k < WinCols; k++) begin : g_col
    uad_win_col u_col (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (win_en),
      .col_i  (win_chain[k+1]),
      .col_o  (win_chain[k])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 2: neighbor differences. The upwind side follows the sign of each
  // advection coefficient; a zero coefficient feeds a zero difference.
  // ---------------------------------------------------------------------
  sample_t                 cc;
  sample_t                 ww;
  sample_t                 ee;
  sample_t                 nn;
  sample_t                 ss;
  logic signed [DiffW-1:0] diff_d [NumTerms];
  logic signed [DiffW-1:0] diff_q [NumTerms];
  logic signed [CoefW-1:0] coef   [NumTerms];
  sample_t                 c2_q;
  sample_t                 c3_q;
  sample_t                 c4_q;

  assign cc = win_chain[1].mid;
  assign ww = win_chain[0].mid;
  assign ee = win_chain[2].mid;
  assign nn = win_chain[1].top;
  assign ss = win_chain[1].bot;

  always_comb begin
    diff_d[TermDiffW] = DiffW'(ww) - DiffW'(cc);
    diff_d[TermDiffE] = DiffW'(ee) - DiffW'(cc);
    diff_d[TermDiffN] = DiffW'(nn) - DiffW'(cc);
    diff_d[TermDiffS] = DiffW'(ss) - DiffW'(cc);

    if (axc_q[CoefW-1]) begin
      diff_d[TermAdvX] = DiffW'(cc) - DiffW'(ee);
    end else if (axc_q != '0) begin
      diff_d[TermAdvX] = DiffW'(ww) - DiffW'(cc);
    end else begin
      diff_d[TermAdvX] = '0;
    end

    if (ayc_q[CoefW-1]) begin
      diff_d[TermAdvY] = DiffW'(cc) - DiffW'(ss);
    end else if (ayc_q != '0) begin
      diff_d[TermAdvY] = DiffW'(nn) - DiffW'(cc);
    end else begin
      diff_d[TermAdvY] = '0;
    end
  end

  assign coef[TermAdvX]  = axc_q;
  assign coef[TermAdvY]  = ayc_q;
  assign coef[TermDiffW] = $signed({1'b0, dxc_q});
  assign coef[TermDiffE] = $signed({1'b0, dxc_q});
  assign coef[TermDiffN] = $signed({1'b0, dyc_q});
  assign coef[TermDiffS] = $signed({1'b0, dyc_q});

  // ---------------------------------------------------------------------
  // Stages 3 and 4: six term lanes, each a product then a rounding step.
  // ---------------------------------------------------------------------
  logic signed [TermW-1:0] term [NumTerms];

  for (genvar t = 0; t < NumTerms; t++) begin : g_term
    uad_term #(
      .FRAC_BITS (FRAC_BITS)
    ) u_term (
      .clk_i  (clk_i),
      .en_i   (adv),
      .coef_i (coef[t]),
      .diff_i (diff_q[t]),
      .term_o (term[t])
    );
  end

  // ---------------------------------------------------------------------
  // Stages 5 to 7: adder tree over the centre and the six terms, then
  // saturation to 32 bits into the output register.
  // ---------------------------------------------------------------------
  logic signed [SumW-1:0] pair_d [4];
  logic signed [SumW-1:0] pair_q [4];
  logic signed [SumW-1:0] quad_d [2];
  logic signed [SumW-1:0] quad_q [2];
  logic signed [SumW-1:0] total;
  logic [SumW-SampleW:0]  total_hi;
  sample_t                sat_value;
  out_item_t              out_d;
  out_item_t              out_q;

  assign pair_d[0] = SumW'(term[TermAdvX]) + SumW'(term[TermAdvY]);
  assign pair_d[1] = SumW'(term[TermDiffW]) + SumW'(term[TermDiffE]);
  assign pair_d[2] = SumW'(term[TermDiffN]) + SumW'(term[TermDiffS]);
  assign pair_d[3] = SumW'(c4_q);

  assign quad_d[0] = pair_q[0] + pair_q[1];
  assign quad_d[1] = pair_q[2] + pair_q[3];

  assign total    = quad_q[0] + quad_q[1];
  assign total_hi = total[SumW-1:SampleW-1];

  always_comb begin
    if ((&total_hi) || !(|total_hi)) begin
      sat_value = total[SampleW-1:0];
    end else if (total[SumW-1]) begin
      sat_value = SatMin;
    end else begin
      sat_value = SatMax;
    end
    out_d.new_value  = sat_value;
    out_d.cell_row   = meta_q[OutStage-1].row;
    out_d.cell_col   = meta_q[OutStage-1].col;
    out_d.frame_last = meta_q[OutStage-1].last;
  end

  // ---------------------------------------------------------------------
  // Pipeline registers. Only cells that produce a result keep their valid
  // bit past stage 0.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[OutStage-1:1], v_q[0] && emit0_q, accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_sample_q <= in_item_i.sample;
      emit0_q     <= emit_d;
      meta_q[0]   <= meta_d;
      for (int k = 1; k < OutStage; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
      diff_q <= diff_d;
      c2_q   <= cc;
      c3_q   <= c2_q;
      c4_q   <= c3_q;
      pair_q <= pair_d;
      quad_q <= quad_d;
      out_q  <= out_d;
    end
  end

  assign out_valid_o = v_q[OutStage];
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  // Input back-pressure only ever comes from a waiting, stalled result.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // Every transfer enters stage 0.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted sample did not enter the pipeline");

  // After a transfer the column counter lies inside the grid it was
  // computed for.
  a_col_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (col_q < $past(w_eff)))
    else $error("column counter beyond grid width");

endmodule

`default_nettype wire
